>>> design/grid_component_threshold_search_top_macros.svh
// assertion macros for the grid component threshold search block
// used by grid_component_threshold_search_top; needs clk_i and rst_ni in scope
`ifndef GRID_COMPONENT_THRESHOLD_SEARCH_TOP_MACROS_SVH
`define GRID_COMPONENT_THRESHOLD_SEARCH_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define GCTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/gcts_pkg.sv
// shared types and constants for the grid component threshold search block
// no dependencies
`default_nettype none

package gcts_pkg;

  localparam int unsigned SRCH_W     = 21;
  localparam int unsigned OUT_W      = 20;
  localparam int unsigned SIDE_REG_W = 7;

  localparam logic [SRCH_W-1:0] SEARCH_BOUND = 21'd1000005;
  localparam logic [OUT_W-1:0]  THR_MIN      = 20'd1;
  localparam logic [OUT_W-1:0]  THR_MAX      = 20'd1000006;

  // register index of grid_side
  localparam logic REG_GRID_SIDE = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_PINIT,
    S_CLR,
    S_EDGE,
    S_HA,
    S_HB,
    S_FRA,
    S_FWA,
    S_FRB,
    S_FWB,
    S_SZ,
    S_SZA,
    S_SZB,
    S_DECIDE,
    S_OUT
  } gcts_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_clr;
    logic load_wr;
    logic search_init;
    logic probe_init;
    logic clr_wr;
    logic scan_init;
    logic next_edge;
    logic cap_ha;
    logic rd_hb;
    logic find_a;
    logic find_step;
    logic set_ra;
    logic set_rb;
    logic cap_sa;
    logic rd_sb;
    logic merge;
    logic decide;
  } gcts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_last;
    logic clr_last;
    logic scan_done;
    logic edge_valid;
    logic found;
    logic close;
    logic par_root;
    logic same_root;
    logic search_more;
  } gcts_status_t;

endpackage

`default_nettype wire

>>> design/gcts_ctrl.sv
// sequencer for loading, probe clearing, edge merging and the threshold search
// depends on gcts_pkg
`default_nettype none

module gcts_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  cfg_wr_i,
  input  wire gcts_pkg::gcts_status_t st_i,
  output gcts_pkg::gcts_cmd_t        cmd_o,
  output logic                       busy_o,
  output logic                       done_o
);

  gcts_pkg::gcts_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.load_clr   = cfg_wr_i;
    busy_o           = (state_q != gcts_pkg::S_IDLE);
    done_o           = 1'b0;
    case (state_q)
      gcts_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load_wr = 1'b1;
          if (st_i.load_last) begin
            cmd_o.search_init = 1'b1;
            state_d           = gcts_pkg::S_CHECK;
          end
        end
      end
      gcts_pkg::S_CHECK: begin
        state_d = st_i.search_more ? gcts_pkg::S_PINIT : gcts_pkg::S_OUT;
      end
      gcts_pkg::S_PINIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = gcts_pkg::S_CLR;
      end
      gcts_pkg::S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (st_i.clr_last) begin
          cmd_o.scan_init = 1'b1;
          state_d         = gcts_pkg::S_EDGE;
        end
      end
      gcts_pkg::S_EDGE: begin
        if (st_i.scan_done || st_i.found) begin
          state_d = gcts_pkg::S_DECIDE;
        end else if (!st_i.edge_valid) begin
          cmd_o.next_edge = 1'b1;
        end else begin
          state_d = gcts_pkg::S_HA;
        end
      end
      gcts_pkg::S_HA: begin
        cmd_o.cap_ha = 1'b1;
        cmd_o.rd_hb  = 1'b1;
        state_d      = gcts_pkg::S_HB;
      end
      gcts_pkg::S_HB: begin
        if (st_i.close) begin
          cmd_o.find_a = 1'b1;
          state_d      = gcts_pkg::S_FRA;
        end else begin
          cmd_o.next_edge = 1'b1;
          state_d         = gcts_pkg::S_EDGE;
        end
      end
      gcts_pkg::S_FRA: begin
        state_d = gcts_pkg::S_FWA;
      end
      gcts_pkg::S_FWA: begin
        if (st_i.par_root) begin
          cmd_o.set_ra = 1'b1;
          state_d      = gcts_pkg::S_FRB;
        end else begin
          cmd_o.find_step = 1'b1;
          state_d         = gcts_pkg::S_FRA;
        end
      end
      gcts_pkg::S_FRB: begin
        state_d = gcts_pkg::S_FWB;
      end
      gcts_pkg::S_FWB: begin
        if (st_i.par_root) begin
          cmd_o.set_rb = 1'b1;
          state_d      = gcts_pkg::S_SZ;
        end else begin
          cmd_o.find_step = 1'b1;
          state_d         = gcts_pkg::S_FRB;
        end
      end
      gcts_pkg::S_SZ: begin
        if (st_i.same_root) begin
          cmd_o.next_edge = 1'b1;
          state_d         = gcts_pkg::S_EDGE;
        end else begin
          state_d = gcts_pkg::S_SZA;
        end
      end
      gcts_pkg::S_SZA: begin
        cmd_o.cap_sa = 1'b1;
        cmd_o.rd_sb  = 1'b1;
        state_d      = gcts_pkg::S_SZB;
      end
      gcts_pkg::S_SZB: begin
        cmd_o.merge     = 1'b1;
        cmd_o.next_edge = 1'b1;
        state_d         = gcts_pkg::S_EDGE;
      end
      gcts_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = gcts_pkg::S_CHECK;
      end
      gcts_pkg::S_OUT: begin
        done_o  = 1'b1;
        state_d = gcts_pkg::S_IDLE;
      end
      default: begin
        state_d = gcts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/gcts_dp.sv
// datapath: height memory, union-find tables, scan counters and search bounds
// depends on gcts_pkg
`default_nettype none

module gcts_dp #(
  parameter int unsigned MAX_SIDE    = 64,
  parameter int unsigned HEIGHT_BITS = 20
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [gcts_pkg::SIDE_REG_W-1:0]      side_i,
  input  wire logic [HEIGHT_BITS-1:0]               height_i,
  input  wire gcts_pkg::gcts_cmd_t                  cmd_i,
  output gcts_pkg::gcts_status_t                    st_o,
  output logic [gcts_pkg::OUT_W-1:0]                min_threshold_o
);

  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned NCELL = MAX_SIDE * MAX_SIDE;
  localparam int unsigned CW    = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int unsigned NW    = $clog2(NCELL + 1);
  localparam int unsigned HW    = HEIGHT_BITS;
  localparam int unsigned RW    = gcts_pkg::SRCH_W;

  logic [SW-1:0] n;
  logic [NW-1:0] cells;
  logic [NW-1:0] need;

  // clamp the side register into the supported range
  always_comb begin
    if (side_i == '0) begin
      n = SW'(1);
    end else if (32'(side_i) > MAX_SIDE) begin
      n = SW'(MAX_SIDE);
    end else begin
      n = SW'(side_i);
    end
  end

  assign cells = NW'(32'(n) * 32'(n));
  assign need  = cells >> 1;

  // load counter
  logic [NW-1:0] load_cnt_q;
  logic [NW-1:0] load_idx;
  logic [NW-1:0] load_inc;

  assign load_idx = (load_cnt_q >= cells) ? '0 : load_cnt_q;
  assign load_inc = load_idx + NW'(1);
  assign st_o.load_last = (load_inc >= cells);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (cmd_i.load_clr) begin
      load_cnt_q <= '0;
    end else if (cmd_i.load_wr) begin
      load_cnt_q <= st_o.load_last ? '0 : load_inc;
    end
  end

  // search bounds
  logic [RW-1:0] low_q, high_q, mid_q;
  logic          found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= gcts_pkg::SEARCH_BOUND;
      mid_q  <= '0;
    end else if (cmd_i.search_init) begin
      low_q  <= '0;
      high_q <= gcts_pkg::SEARCH_BOUND;
    end else if (cmd_i.probe_init) begin
      mid_q <= RW'(((RW + 1)'(low_q) + (RW + 1)'(high_q) + (RW + 1)'(1)) >> 1);
    end else if (cmd_i.decide) begin
      if (found_q || (need <= NW'(1))) begin
        high_q <= mid_q - RW'(1);
      end else begin
        low_q <= mid_q;
      end
    end
  end

  assign st_o.search_more = (low_q < high_q);
  assign min_threshold_o  = gcts_pkg::OUT_W'(low_q + RW'(1));

  // clear sweep and edge scan counters
  logic [NW-1:0] clr_q;
  logic [SW-1:0] i_q, j_q;
  logic [NW-1:0] c_q;
  logic          dir_q;
  logic [CW-1:0] a_idx, b_idx;

  assign st_o.clr_last  = (clr_q == cells - NW'(1));
  assign st_o.scan_done = (i_q == n);
  assign st_o.edge_valid = dir_q ? (({1'b0, j_q} + (SW + 1)'(1)) < {1'b0, n})
                                 : (({1'b0, i_q} + (SW + 1)'(1)) < {1'b0, n});
  assign a_idx = c_q[CW-1:0];
  assign b_idx = dir_q ? a_idx + CW'(1) : a_idx + CW'(n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      i_q   <= '0;
      j_q   <= '0;
      c_q   <= '0;
      dir_q <= 1'b0;
    end else begin
      if (cmd_i.probe_init) begin
        clr_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_q <= clr_q + NW'(1);
      end
      if (cmd_i.scan_init) begin
        i_q   <= '0;
        j_q   <= '0;
        c_q   <= '0;
        dir_q <= 1'b0;
      end else if (cmd_i.next_edge) begin
        if (!dir_q) begin
          dir_q <= 1'b1;
        end else begin
          dir_q <= 1'b0;
          c_q   <= c_q + NW'(1);
          if (j_q + SW'(1) == n) begin
            j_q <= '0;
            i_q <= i_q + SW'(1);
          end else begin
            j_q <= j_q + SW'(1);
          end
        end
      end
    end
  end

  // height memory
  logic [HW-1:0] hmem [NCELL];
  logic [HW-1:0] hrd_q;
  logic [HW-1:0] ha_q;
  logic [CW-1:0] h_raddr;
  logic [HW-1:0] hdiff;

  assign h_raddr = cmd_i.rd_hb ? b_idx : a_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      hmem[load_idx[CW-1:0]] <= height_i;
    end
    hrd_q <= hmem[h_raddr];
    if (cmd_i.cap_ha) begin
      ha_q <= hrd_q;
    end
  end

  assign hdiff      = (ha_q > hrd_q) ? ha_q - hrd_q : hrd_q - ha_q;
  assign st_o.close = (33'(hdiff) <= 33'(mid_q));

  // union-find tables
  logic [CW-1:0] pmem [NCELL];
  logic [NW-1:0] smem [NCELL];
  logic [CW-1:0] prd_q;
  logic [NW-1:0] srd_q, sa_q;
  logic [CW-1:0] x_q, ra_q, rb_q;
  logic [CW-1:0] s_raddr;
  logic [NW-1:0] sum;
  logic          a_small;

  assign s_raddr        = cmd_i.rd_sb ? rb_q : ra_q;
  assign sum            = sa_q + srd_q;
  assign a_small        = (sa_q < srd_q);
  assign st_o.par_root  = (prd_q == x_q);
  assign st_o.same_root = (ra_q == rb_q);
  assign st_o.found     = found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      pmem[clr_q[CW-1:0]] <= clr_q[CW-1:0];
      smem[clr_q[CW-1:0]] <= NW'(1);
    end else if (cmd_i.merge) begin
      if (a_small) begin
        pmem[ra_q] <= rb_q;
        smem[rb_q] <= sum;
      end else begin
        pmem[rb_q] <= ra_q;
        smem[ra_q] <= sum;
      end
    end
    prd_q <= pmem[x_q];
    srd_q <= smem[s_raddr];
    if (cmd_i.cap_sa) begin
      sa_q <= srd_q;
    end
    if (cmd_i.find_a) begin
      x_q <= a_idx;
    end else if (cmd_i.find_step) begin
      x_q <= prd_q;
    end else if (cmd_i.set_ra) begin
      x_q <= b_idx;
    end
    if (cmd_i.set_ra) begin
      ra_q <= x_q;
    end
    if (cmd_i.set_rb) begin
      rb_q <= x_q;
    end
  end

  // a region reached the target size during this probe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.probe_init) begin
      found_q <= 1'b0;
    end else if (cmd_i.merge && (sum >= need)) begin
      found_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> design/grid_component_threshold_search_top.sv
// channel   direction  signals                        beat taken when
// cfg       in/out     psel penable pwrite paddr ...  psel & penable & pwrite & pready
// height    in         start height_i                 start & !busy
// result    out        result_valid_o min_threshold_o result_valid_o (one cycle)
//
// a height loads on each start beat while idle; the last cell of the grid starts the search
// about 20 probes; each clears the union-find tables, then scans the edges and decides
// per edge: edges off the grid are skipped; when the two heights are close, find walks
// locate both roots, and the regions merge when the roots differ
// a probe stops scanning once a region reaches half the grid
// rst_ni clears control state; the result strobe cannot be stalled
// top level: config register, controller and datapath; uses gcts_pkg and the macro header
`default_nettype none

`include "grid_component_threshold_search_top_macros.svh"

module grid_component_threshold_search_top #(
  parameter int unsigned MAX_SIDE    = 64,
  parameter int unsigned HEIGHT_BITS = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [HEIGHT_BITS-1:0]        height_i,
  output logic                               result_valid_o,
  output logic [gcts_pkg::OUT_W-1:0]         min_threshold_o
);

  logic [gcts_pkg::SIDE_REG_W-1:0] side_q;
  logic                            cfg_wr;
  logic                            thr_ok;
  gcts_pkg::gcts_cmd_t             cmd;
  gcts_pkg::gcts_status_t          st;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == gcts_pkg::REG_GRID_SIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= gcts_pkg::SIDE_REG_W'(1);
    end else if (cfg_wr) begin
      side_q <= pwdata[gcts_pkg::SIDE_REG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == gcts_pkg::REG_GRID_SIDE) ? 32'(side_q) : '0;

  gcts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cfg_wr_i (cfg_wr),
    .st_i     (st),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (result_valid_o)
  );

  gcts_dp #(
    .MAX_SIDE    (MAX_SIDE),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .side_i          (side_q),
    .height_i        (height_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .min_threshold_o (min_threshold_o)
  );

  // result within the legal threshold range
  assign thr_ok = (min_threshold_o >= gcts_pkg::THR_MIN) &&
                  (min_threshold_o <= gcts_pkg::THR_MAX);

  // checks
  `GCTS_ASSERT_NOW(a_done_busy, result_valid_o, busy, "result beat outside a search")
  `GCTS_ASSERT_NEXT(a_done_once, result_valid_o, !result_valid_o && !busy, "result beat repeated")
  `GCTS_ASSERT_NOW(a_done_range, result_valid_o, thr_ok, "threshold out of range")
  `GCTS_ASSERT_NOW(a_merge_distinct, cmd.merge, !st.same_root, "merge of one root with itself")

endmodule

`default_nettype wire

>>> tb/grid_component_threshold_search_top_tb.sv
// testbench for the grid component threshold search block: loads height grids,
// predicts the least qualifying threshold with a union-find search, checks each result
// depends on gcts_pkg and grid_component_threshold_search_top
`default_nettype none

module grid_component_threshold_search_top_tb;

  localparam int unsigned MAX_SIDE = 64;
  localparam int unsigned CELLS    = MAX_SIDE * MAX_SIDE;
  localparam logic [2:0]  SIDE_ADDR = {gcts_pkg::REG_GRID_SIDE, 2'b00};
  localparam longint      CYCLE_LIMIT = 64'd20000000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [19:0] height_i;
  logic        result_valid_o;
  logic [19:0] min_threshold_o;

  grid_component_threshold_search_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .height_i, .result_valid_o, .min_threshold_o
  );

  // predictor state
  logic [6:0]  side_reg;
  int unsigned cells_loaded;
  logic [19:0] grid_heights [CELLS];
  int unsigned uf_parent [CELLS];
  int unsigned uf_count [CELLS];
  logic [19:0] thresholds_due [$];

  int  mismatches;
  bit  failed;
  bit  idle_gaps;
  longint cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_component_threshold_search_top_tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned side_eff();
    if (side_reg == 7'd0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  function automatic int unsigned root_of(int unsigned a);
    int unsigned r;
    int unsigned nx;
    r = a;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (uf_parent[a] != r) begin
      nx = uf_parent[a];
      uf_parent[a] = r;
      a = nx;
    end
    return r;
  endfunction

  function automatic void join_cells(int unsigned a, int unsigned b);
    int unsigned t;
    a = root_of(a);
    b = root_of(b);
    if (a == b) return;
    if (uf_count[a] < uf_count[b]) begin
      t = a; a = b; b = t;
    end
    uf_count[a] += uf_count[b];
    uf_parent[b] = a;
  endfunction

  function automatic bit near(int unsigned a, int unsigned b, int unsigned d);
    int unsigned x, y;
    x = grid_heights[a];
    y = grid_heights[b];
    return ((x > y) ? x - y : y - x) <= d;
  endfunction

  // one probe: does some region reach half the grid at threshold d
  function automatic bit region_reaches_half(int unsigned n, int unsigned d);
    int unsigned need, c;
    need = (n * n) / 2;
    for (int unsigned k = 0; k < n * n; k++) begin
      uf_parent[k] = k;
      uf_count[k] = 1;
    end
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < n; j++) begin
        c = i * n + j;
        if (i + 1 < n && near(c, c + n, d)) join_cells(c, c + n);
        if (j + 1 < n && near(c, c + 1, d)) join_cells(c, c + 1);
      end
    for (c = 0; c < n * n; c++)
      if (uf_count[root_of(c)] >= need) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_height(logic [19:0] h);
    int unsigned n, idx, lo, hi, mid;
    n = side_eff();
    idx = cells_loaded;
    if (idx >= n * n) idx = 0;
    grid_heights[idx] = h;
    cells_loaded = idx + 1;
    if (cells_loaded < n * n) return;
    cells_loaded = 0;
    lo = 0;
    hi = gcts_pkg::SEARCH_BOUND;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (!region_reaches_half(n, mid)) lo = mid;
      else hi = mid - 1;
    end
    thresholds_due = {thresholds_due, 20'(lo + 1)};
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (thresholds_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", min_threshold_o);
      end else begin
        if (min_threshold_o !== thresholds_due[0]) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("min_threshold mismatch: expected %0d actual %0d",
                     thresholds_due[0], min_threshold_o);
        end
        void'(thresholds_due.pop_front());
      end
    end
  end

  // idle burst with start low
  task automatic random_gap();
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // send one height beat; start stays high for a following beat
  task automatic send_height(logic [19:0] h);
    random_gap();
    start <= 1'b1;
    height_i <= h;
    do @(posedge clk_i); while (busy);
    predict_height(h);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (thresholds_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // register write, only while idle
  task automatic write_side(logic [6:0] v);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= SIDE_ADDR; pwdata <= {$urandom()} & 32'hFFFF_FF80 | v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    side_reg = v;
    cells_loaded = 0;
  endtask

  task automatic send_grid(int unsigned mode);
    int unsigned n;
    logic [19:0] base;
    n = side_eff();
    base = 20'($urandom());
    for (int unsigned k = 0; k < n * n; k++) begin
      case (mode)
        0: send_height(20'($urandom()));
        1: send_height(base + 20'($urandom_range(0, 40)));
        2: send_height((k % 2) ? 20'hFFFFF : 20'h0);
        default: send_height(base);
      endcase
    end
  endtask

  // extremes of side and height, special cases
  task automatic test_directed();
    write_side(7'd1);
    send_height(20'h0);
    send_height(20'hFFFFF);
    write_side(7'd0);
    send_height(20'h5A5A5);
    write_side(7'd2);
    send_height(20'h0); send_height(20'hFFFFF);
    send_height(20'hFFFFF); send_height(20'h0);
    write_side(7'd3);
    send_grid(3);
    // write in the middle of a grid restarts loading
    send_height(20'h12345); send_height(20'h54321);
    write_side(7'd2);
    send_grid(2);
  endtask

  // oversized side clamps, then a partial grid is dropped by a new side
  task automatic test_large_sides();
    write_side(7'd127);
    for (int unsigned k = 0; k < 16; k++) send_height(20'($urandom()));
    write_side(7'd12);
    send_grid(1);
  endtask

  task automatic test_random();
    int unsigned sent;
    sent = 0;
    while (sent < 320) begin
      write_side(7'($urandom_range(2, 6)));
      send_grid($urandom_range(0, 3));
      sent += side_eff() * side_eff();
      if (sent > 250) idle_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; height_i = '0;
    side_reg = 7'd1; cells_loaded = 0;
    mismatches = 0; failed = 1'b0; idle_gaps = 1'b1; cycle_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_large_sides();
    test_random();
    drain();
    if (!failed) begin
      $display("grid_component_threshold_search_top_tb: PASS");
    end else begin
      $display("grid_component_threshold_search_top_tb: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
